/* hdl/glos_pkg.sv */
// ----------------------------------------------------------------------------
// glos_pkg
// Shared types and constants for the grid line-of-sight engine.
// ----------------------------------------------------------------------------
package glos_pkg;

  localparam int MAP_WIDTH  = 128;
  localparam int MAP_HEIGHT = 128;

  localparam int COORD_W = 7;                   // request coordinate width
  localparam int COL_W   = $clog2(MAP_WIDTH);
  localparam int ROW_W   = $clog2(MAP_HEIGHT);
  localparam int ERR_W   = COORD_W + 3;         // Bresenham error term, signed
  localparam int TDATA_W = 32;                  // 29 payload bits, byte padded

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_OUT
  } state_e;

  // Access to the cell map from the walk sequencer
  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               wr_bit;
  } map_req_t;

endpackage

/* hdl/glos_map.sv */
// ----------------------------------------------------------------------------
// glos_map
// Transparency map: one row of cells per memory word, a valid bit per row.
// An unwritten row reads as all opaque, so reset needs no clearing pass.
// ----------------------------------------------------------------------------
module glos_map (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  glos_pkg::map_req_t req_i,
  output logic              cell_clear_o   // cell of the previous read request
);

  logic [glos_pkg::MAP_WIDTH-1:0] mem [glos_pkg::MAP_HEIGHT];
  logic [glos_pkg::MAP_HEIGHT-1:0] row_vld_q;

  logic [glos_pkg::MAP_WIDTH-1:0] rd_row_q;
  logic [glos_pkg::COL_W-1:0]     rd_col_q;
  logic                           rd_ok_q;

  logic [glos_pkg::ROW_W-1:0] row;
  logic [glos_pkg::COL_W-1:0] col;
  logic                       in_map;

  assign row    = req_i.y[glos_pkg::ROW_W-1:0];
  assign col    = req_i.x[glos_pkg::COL_W-1:0];
  assign in_map = (int'(req_i.x) < glos_pkg::MAP_WIDTH) &&
                  (int'(req_i.y) < glos_pkg::MAP_HEIGHT);

  // First write to a row fills the rest of it with opaque cells
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && in_map) begin
      if (row_vld_q[row]) begin
        mem[row][col] <= req_i.wr_bit;
      end else begin
        mem[row] <= glos_pkg::MAP_WIDTH'(req_i.wr_bit) << col;
      end
    end
    if (req_i.rd_en) begin
      rd_row_q <= mem[row];
      rd_col_q <= col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (req_i.wr_en && in_map) begin
        row_vld_q[row] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_ok_q <= in_map && row_vld_q[row];
      end
    end
  end

  assign cell_clear_o = rd_ok_q && rd_row_q[rd_col_q];

endmodule

/* hdl/grid_line_of_sight.sv */
// ----------------------------------------------------------------------------
// grid_line_of_sight
// Bresenham line-of-sight engine over a 128 x 128 transparency map.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel; tuser selects the kind. A write
//   (tuser = 0) sets the transparency bit of cell (start_x, start_y) and
//   produces no result. A query (tuser = 1) walks the Bresenham line from
//   start to end and returns one result on m_axis: tdata[0] = 1 when no
//   opaque cell lies strictly between the two end cells.
// Timing:
//   A query is loaded on accept, then walks the line in ST_WALK and
//   holds its result in ST_OUT until taken. The walk stops early at the
//   first opaque cell. The walk advances one line step per cycle because
//   the single map read port is read once per step, its registered data
//   being checked while the next step is computed.
//   s_axis_tready is low from query accept until its result is taken, so
//   a stalled receiver holds the result and blocks new requests.
// Reset:
//   Every cell reads opaque right after reset; per-row valid bits stand in
//   for clearing the map, so requests are accepted at once.
// ----------------------------------------------------------------------------
module grid_line_of_sight (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [6:0] start_x, [13:7] start_y, [20:14] end_x, [27:21] end_y,
  // [28] cell_clear, [31:29] zero
  input  logic [glos_pkg::TDATA_W-1:0] s_axis_tdata,
  input  logic                         s_axis_tuser,   // [0] command
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata    // [0] visible, [7:1] zero
);

  localparam int CW = glos_pkg::COORD_W;
  localparam int EW = glos_pkg::ERR_W;

  glos_pkg::state_e   state_q, state_d;
  glos_pkg::map_req_t map_req;
  logic               map_clear;

  logic [CW-1:0]        cx_q, cx_d, cy_q, cy_d, tx_q, tx_d, ty_q, ty_d;
  logic [CW-1:0]        dx_q, dx_d, dy_q, dy_d;
  logic                 xneg_q, xneg_d, yneg_q, yneg_d;
  logic signed [EW-1:0] err_q, err_d;
  logic                 chk_q, chk_d;
  logic                 vis_q, vis_d;

  // request fields
  logic [CW-1:0] in_sx, in_sy, in_ex, in_ey;
  logic          in_clear;

  // step unit
  logic signed [EW:0]   e2;
  logic                 step_x, step_y;
  logic signed [EW-1:0] err_n;
  logic [CW-1:0]        cx_n, cy_n;

  assign in_sx    = s_axis_tdata[CW-1:0];
  assign in_sy    = s_axis_tdata[2*CW-1:CW];
  assign in_ex    = s_axis_tdata[3*CW-1:2*CW];
  assign in_ey    = s_axis_tdata[4*CW-1:3*CW];
  assign in_clear = s_axis_tdata[4*CW];

  always_comb begin
    e2     = {err_q, 1'b0};
    step_x = e2 > -$signed({2'b00, dy_q});
    step_y = e2 < $signed({2'b00, dx_q});
    err_n  = err_q - (step_x ? $signed({3'b000, dy_q}) : EW'(0))
                   + (step_y ? $signed({3'b000, dx_q}) : EW'(0));
    cx_n   = step_x ? (xneg_q ? cx_q - 1'b1 : cx_q + 1'b1) : cx_q;
    cy_n   = step_y ? (yneg_q ? cy_q - 1'b1 : cy_q + 1'b1) : cy_q;
  end

  always_comb begin
    state_d       = state_q;
    cx_d          = cx_q;
    cy_d          = cy_q;
    tx_d          = tx_q;
    ty_d          = ty_q;
    dx_d          = dx_q;
    dy_d          = dy_q;
    xneg_d        = xneg_q;
    yneg_d        = yneg_q;
    err_d         = err_q;
    chk_d         = chk_q;
    vis_d         = vis_q;
    map_req       = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;

    unique case (state_q)
      glos_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == glos_pkg::CMD_QUERY) begin
            cx_d    = in_sx;
            cy_d    = in_sy;
            tx_d    = in_ex;
            ty_d    = in_ey;
            dx_d    = (in_ex > in_sx) ? in_ex - in_sx : in_sx - in_ex;
            dy_d    = (in_ey > in_sy) ? in_ey - in_sy : in_sy - in_ey;
            xneg_d  = !(in_sx < in_ex);
            yneg_d  = !(in_sy < in_ey);
            err_d   = $signed({3'b000, dx_d}) - $signed({3'b000, dy_d});
            chk_d   = 1'b0;
            state_d = glos_pkg::ST_WALK;
          end else begin
            map_req.wr_en  = 1'b1;
            map_req.x      = in_sx;
            map_req.y      = in_sy;
            map_req.wr_bit = in_clear;
          end
        end
      end

      glos_pkg::ST_WALK: begin
        if (chk_q && !map_clear) begin
          vis_d   = 1'b0;
          state_d = glos_pkg::ST_OUT;
        end else if (cx_q == tx_q && cy_q == ty_q) begin
          vis_d   = 1'b1;
          state_d = glos_pkg::ST_OUT;
        end else begin
          cx_d  = cx_n;
          cy_d  = cy_n;
          err_d = err_n;
          // the end cell itself is never tested
          if (cx_n == tx_q && cy_n == ty_q) begin
            chk_d = 1'b0;
          end else begin
            map_req.rd_en = 1'b1;
            map_req.x     = cx_n;
            map_req.y     = cy_n;
            chk_d         = 1'b1;
          end
        end
      end

      glos_pkg::ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_d = glos_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = glos_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glos_pkg::ST_IDLE;
      chk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      chk_q   <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    tx_q   <= tx_d;
    ty_q   <= ty_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    xneg_q <= xneg_d;
    yneg_q <= yneg_d;
    err_q  <= err_d;
    vis_q  <= vis_d;
  end

  assign m_axis_tdata = {7'b0000000, vis_q};

  glos_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (map_req),
    .cell_clear_o(map_clear)
  );

endmodule
